FILE: src/hmsp_pkg.sv
// Package for the duration text parser: payload structs, codes and constants.
// Used by every module of the parser; depends on nothing.
`timescale 1ns / 1ps

package hmsp_pkg;

    localparam int unsigned PART_BITS  = 40;
    localparam int unsigned TOTAL_BITS = 48;
    localparam int unsigned FRAC_BITS  = 10;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned MS_PER_HOUR = 3600000;
    localparam int unsigned MS_PER_MIN  = 60000;
    localparam int unsigned MS_PER_SEC  = 1000;
    localparam int unsigned COUNT_SAT   = 3;

    localparam longint unsigned TOTAL_LIMIT = (64'd1 << TOTAL_BITS) - 64'd1;
    localparam longint unsigned HOUR_MAX    = TOTAL_LIMIT / MS_PER_HOUR;
    localparam longint unsigned MIN_MAX     = TOTAL_LIMIT / MS_PER_MIN;
    localparam longint unsigned SEC_MAX     = TOTAL_LIMIT / MS_PER_SEC;
    localparam int unsigned HOUR_W = $clog2(HOUR_MAX + 64'd1);
    localparam int unsigned MIN_W  = $clog2(MIN_MAX + 64'd1);
    localparam int unsigned SEC_W  = $clog2(SEC_MAX + 64'd1);

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_FORMAT   = 2'd1,
        ERR_OVERFLOW = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_PART  = 2'd1,
        PH_FRAC  = 2'd2,
        PH_TRAIL = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        t_err              status;
        logic [TOTAL_BITS-1:0] total_ms;
    } t_out_item;

    typedef struct packed {
        t_err                 err;
        logic [1:0]           parts_seen;
        logic [PART_BITS-1:0] first_value;
        logic [PART_BITS-1:0] second_value;
        logic [PART_BITS-1:0] current_value;
        logic [FRAC_BITS-1:0] fraction_value;
        logic [1:0]           fraction_digits;
    } t_job;

endpackage

FILE: src/hmsp_front.sv
// Front end of the duration text parser: byte-wise parse state machine.
// Pushes one finished job per string into the queue. Depends on hmsp_pkg.
`timescale 1ns / 1ps

module hmsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hmsp_pkg::t_in_item i_in_data,
    input  logic              i_queue_full,
    output logic              o_push,
    output hmsp_pkg::t_job    o_job
);
    import hmsp_pkg::*;

    t_phase               r_phase, n_phase;
    logic [1:0]           r_parts, n_parts;
    logic [1:0]           r_digits, n_digits;
    logic [PART_BITS-1:0] r_first, n_first;
    logic [PART_BITS-1:0] r_second, n_second;
    logic [PART_BITS-1:0] r_cur, n_cur;
    logic [FRAC_BITS-1:0] r_frac, n_frac;
    logic [1:0]           r_fdig, n_fdig;
    t_err                 r_err, n_err;

    logic [7:0]           w_c;
    logic [3:0]           w_digit;
    logic                 w_is_digit;
    logic                 w_is_space;
    logic [PART_BITS+3:0] w_acc;
    logic                 w_acc_ovf;
    logic                 w_accept;
    logic                 w_end_fmt;

    assign w_c        = i_in_data.char_code;
    assign w_digit    = w_c[3:0];
    assign w_is_digit = (w_c >= CHAR_ZERO) && (w_c <= CHAR_NINE);
    assign w_is_space = (w_c == CHAR_SPACE) || ((w_c >= CHAR_TAB) && (w_c <= CHAR_CR));
    assign w_acc      = ((PART_BITS + 4)'(r_cur) << 3) + ((PART_BITS + 4)'(r_cur) << 1)
                        + (PART_BITS + 4)'(w_digit);
    assign w_acc_ovf  = |w_acc[PART_BITS+3:PART_BITS];

    assign o_in_ready = !i_queue_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_push     = w_accept && i_in_data.last_char;

    always_comb begin
        n_phase  = r_phase;
        n_parts  = r_parts;
        n_digits = r_digits;
        n_first  = r_first;
        n_second = r_second;
        n_cur    = r_cur;
        n_frac   = r_frac;
        n_fdig   = r_fdig;
        n_err    = r_err;
        if (r_err != ERR_FORMAT) begin
            case (r_phase)
                PH_LEAD, PH_PART: begin
                    if (w_is_digit) begin
                        n_phase = PH_PART;
                        if (w_acc_ovf) begin
                            n_cur = '1;
                            if (r_err == ERR_NONE) begin
                                n_err = ERR_OVERFLOW;
                            end
                        end else begin
                            n_cur = w_acc[PART_BITS-1:0];
                        end
                        if (r_digits != 2'(COUNT_SAT)) begin
                            n_digits = r_digits + 2'd1;
                        end
                    end else if (r_phase == PH_LEAD) begin
                        if (!w_is_space) begin
                            n_err = ERR_FORMAT;
                        end
                    end else if (w_c == CHAR_COLON) begin
                        if (r_digits == 2'd0 || r_parts >= 2'd2
                                || (r_parts == 2'd1 && r_digits > 2'd2)) begin
                            n_err = ERR_FORMAT;
                        end else begin
                            if (r_parts == 2'd1) begin
                                n_second = r_cur;
                            end else begin
                                n_first = r_cur;
                            end
                            n_parts  = r_parts + 2'd1;
                            n_cur    = '0;
                            n_digits = 2'd0;
                        end
                    end else if (w_c == CHAR_DOT || w_is_space) begin
                        if (r_digits == 2'd0) begin
                            n_err = ERR_FORMAT;
                        end else begin
                            n_phase = (w_c == CHAR_DOT) ? PH_FRAC : PH_TRAIL;
                        end
                    end else begin
                        n_err = ERR_FORMAT;
                    end
                end
                PH_FRAC: begin
                    if (w_is_digit) begin
                        if (r_fdig != 2'(COUNT_SAT)) begin
                            n_frac = (r_frac << 3) + (r_frac << 1) + FRAC_BITS'(w_digit);
                            n_fdig = r_fdig + 2'd1;
                        end
                    end else if (w_is_space && r_fdig != 2'd0) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_err = ERR_FORMAT;
                    end
                end
                default: begin
                    if (!w_is_space) begin
                        n_err = ERR_FORMAT;
                    end
                end
            endcase
        end
    end

    assign w_end_fmt = (n_phase == PH_LEAD)
                    || (n_phase == PH_PART && n_digits == 2'd0)
                    || (n_phase == PH_FRAC && n_fdig == 2'd0);

    always_comb begin
        o_job.err             = w_end_fmt ? ERR_FORMAT : n_err;
        o_job.parts_seen      = n_parts;
        o_job.first_value     = n_first;
        o_job.second_value    = n_second;
        o_job.current_value   = n_cur;
        o_job.fraction_value  = n_frac;
        o_job.fraction_digits = n_fdig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_phase  <= PH_LEAD;
            r_parts  <= 2'd0;
            r_digits <= 2'd0;
            r_first  <= '0;
            r_second <= '0;
            r_cur    <= '0;
            r_frac   <= '0;
            r_fdig   <= 2'd0;
            r_err    <= ERR_NONE;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_parts  <= n_parts;
            r_digits <= n_digits;
            r_first  <= n_first;
            r_second <= n_second;
            r_cur    <= n_cur;
            r_frac   <= n_frac;
            r_fdig   <= n_fdig;
            r_err    <= n_err;
        end
    end

endmodule

FILE: src/hmsp_queue.sv
// Two-entry job queue between the parse front end and the arithmetic back end.
// Depends on hmsp_pkg for the job type.
`timescale 1ns / 1ps

module hmsp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hmsp_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_not_empty,
    input  logic           i_pop,
    output hmsp_pkg::t_job o_job
);
    import hmsp_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_job       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue written while full");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("queue read while empty");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a write");

endmodule

FILE: src/hmsp_back.sv
// Back end of the duration text parser: weights parts into milliseconds,
// checks range and drives the result register. Depends on hmsp_pkg.
`timescale 1ns / 1ps

module hmsp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  hmsp_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hmsp_pkg::t_out_item o_out_data
);
    import hmsp_pkg::*;

    logic                  w_adv;
    logic [PART_BITS-1:0]  w_hours;
    logic [PART_BITS-1:0]  w_minutes;
    logic [FRAC_BITS-1:0]  w_millis;
    logic                  w_range_ovf;
    logic [TOTAL_BITS+1:0] w_sum;

    logic                  r_s1_valid;
    t_err                  r_s1_err;
    logic                  r_s1_ovf;
    logic [TOTAL_BITS-1:0] r_s1_ph;
    logic [TOTAL_BITS-1:0] r_s1_pm;
    logic [TOTAL_BITS-1:0] r_s1_ps;
    logic [FRAC_BITS-1:0]  r_s1_ms;

    logic                  r_s2_valid;
    t_err                  r_s2_err;
    logic                  r_s2_ovf;
    logic [TOTAL_BITS:0]   r_s2_a;
    logic [TOTAL_BITS:0]   r_s2_b;

    logic                  r_out_valid;
    t_out_item             r_out;

    assign w_adv = !r_out_valid || i_out_ready;
    assign o_pop = w_adv && i_job_valid;

    always_comb begin
        case (i_job.parts_seen)
            2'd2: begin
                w_hours   = i_job.first_value;
                w_minutes = i_job.second_value;
            end
            2'd1: begin
                w_hours   = '0;
                w_minutes = i_job.first_value;
            end
            default: begin
                w_hours   = '0;
                w_minutes = '0;
            end
        endcase
        case (i_job.fraction_digits)
            2'd1:    w_millis = FRAC_BITS'(i_job.fraction_value * 7'd100);
            2'd2:    w_millis = FRAC_BITS'(i_job.fraction_value * 4'd10);
            default: w_millis = i_job.fraction_value;
        endcase
    end

    assign w_range_ovf = (64'(w_hours) > HOUR_MAX) || (64'(w_minutes) > MIN_MAX)
                      || (64'(i_job.current_value) > SEC_MAX);

    assign w_sum = (TOTAL_BITS + 2)'(r_s2_a) + (TOTAL_BITS + 2)'(r_s2_b);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_err <= i_job.err;
            r_s1_ovf <= w_range_ovf;
            r_s1_ph  <= TOTAL_BITS'(HOUR_W'(w_hours)) * TOTAL_BITS'(MS_PER_HOUR);
            r_s1_pm  <= TOTAL_BITS'(MIN_W'(w_minutes)) * TOTAL_BITS'(MS_PER_MIN);
            r_s1_ps  <= TOTAL_BITS'(SEC_W'(i_job.current_value)) * TOTAL_BITS'(MS_PER_SEC);
            r_s1_ms  <= w_millis;

            r_s2_err <= r_s1_err;
            r_s2_ovf <= r_s1_ovf;
            r_s2_a   <= (TOTAL_BITS + 1)'(r_s1_ph) + (TOTAL_BITS + 1)'(r_s1_pm);
            r_s2_b   <= (TOTAL_BITS + 1)'(r_s1_ps) + (TOTAL_BITS + 1)'(r_s1_ms);

            if (r_s2_err == ERR_FORMAT) begin
                r_out.status   <= ERR_FORMAT;
                r_out.total_ms <= '0;
            end else if (r_s2_err == ERR_OVERFLOW || r_s2_ovf
                    || 64'(w_sum) > TOTAL_LIMIT) begin
                r_out.status   <= ERR_OVERFLOW;
                r_out.total_ms <= '0;
            end else begin
                r_out.status   <= ERR_NONE;
                r_out.total_ms <= w_sum[TOTAL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= i_job_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ERR_NONE) |-> (o_out_data.total_ms == '0))
        else $error("nonzero total with an error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ERR_NONE || o_out_data.status == ERR_FORMAT
                         || o_out_data.status == ERR_OVERFLOW))
        else $error("undefined status code");

    a_pop_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_s1_valid)
        else $error("popped job did not enter the first stage");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !w_adv) |=> r_s2_valid)
        else $error("job lost in a stalled stage");

endmodule

FILE: src/hms_text_to_ms_parser.sv
// A finished string passes the job queue, stages s1 and s2 and the result register.
// Throughput: one byte per cycle; a backlog of finished strings stalls input when the
// two-entry job queue fills while the output is held. Reset is synchronous, active low,
// and returns the parser to the leading-whitespace phase with queue and pipeline empty.
// Top level of the duration text parser; depends on hmsp_pkg and the hmsp_ modules.
`timescale 1ns / 1ps

module hms_text_to_ms_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hmsp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hmsp_pkg::t_out_item o_out_data
);
    import hmsp_pkg::*;

    logic w_push;
    logic w_full;
    logic w_not_empty;
    logic w_pop;
    t_job w_push_job;
    t_job w_head_job;

    hmsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    hmsp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_job       (w_push_job),
        .o_full      (w_full),
        .o_not_empty (w_not_empty),
        .i_pop       (w_pop),
        .o_job       (w_head_job)
    );

    hmsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_not_empty),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
